// File: hdl/edrf_pkg.sv
// ----------------------------------------------------------------------------
// Echo distance rank filter package
// Shared constants, payload types and register indexes for the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package edrf_pkg;

	localparam int SENSOR_COUNT_DEF  = 10;
	localparam int WINDOW_LENGTH_DEF = 10;

	localparam logic [8:0]  NO_ECHO_CM    = 9'd400;
	localparam logic [3:0]  RANK_RESET    = 4'd4;
	localparam logic [15:0] TIMEOUT_RESET = 16'd23000;

	// Division by 58 as a multiplication by ceil(2^22 / 58); exact for 16-bit times.
	localparam int          RECIP_W  = 17;
	localparam logic [16:0] CM_RECIP = 17'd72316;
	localparam int          CM_SHIFT = 22;
	localparam int          PROD_W   = 16 + RECIP_W;
	localparam int          QUOT_W   = PROD_W - CM_SHIFT;

	// Configuration register indexes.
	localparam int          CFG_INDEX_W = 2;
	localparam logic [1:0]  CFG_RANK    = 2'd0;
	localparam logic [1:0]  CFG_TIMEOUT = 2'd1;

	// Classification queue between the front and the back.
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [3:0]  sensor_index;
		logic        echo_seen;
		logic [15:0] echo_time_us;
	} edrf_in_t;

	typedef struct packed {
		logic [3:0] sensor_out;
		logic [8:0] distance_cm;
		logic       selected_valid;
		logic [8:0] selected_cm;
	} edrf_out_t;

	typedef struct packed {
		logic [3:0] sensor;
		logic [8:0] distance_cm;
		logic       in_range;
	} edrf_cls_t;

endpackage

`default_nettype wire

// File: hdl/edrf_front.sv
// ----------------------------------------------------------------------------
// Echo distance rank filter front end
// Takes in readings, converts echo time to centimetres and checks the sensor.
// ----------------------------------------------------------------------------
`default_nettype none

module edrf_front #(
	parameter int SENSOR_COUNT = edrf_pkg::SENSOR_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  edrf_pkg::edrf_in_t  item,
	input  logic [15:0]         timeout_us,
	output logic                q_push,
	output edrf_pkg::edrf_cls_t q_data,
	input  logic                q_full
);
	import edrf_pkg::*;

	logic                s1_valid_q;
	edrf_in_t            item_s1;
	logic                take;
	logic [PROD_W-1:0]   prod;
	logic [QUOT_W-1:0]   quot;
	logic                timed_out;
	logic [8:0]          cm;

	assign full = s1_valid_q && q_full;
	assign take = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (!q_full) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	assign prod      = PROD_W'(item_s1.echo_time_us) * PROD_W'(CM_RECIP);
	assign quot      = prod[CM_SHIFT +: QUOT_W];
	assign timed_out = !item_s1.echo_seen || (item_s1.echo_time_us >= timeout_us);

	always_comb begin
		if (timed_out || (quot > QUOT_W'(NO_ECHO_CM))) begin
			cm = NO_ECHO_CM;
		end else begin
			cm = quot[8:0];
		end
	end

	assign q_push             = s1_valid_q;
	assign q_data.sensor      = item_s1.sensor_index;
	assign q_data.distance_cm = cm;
	assign q_data.in_range    = 32'(item_s1.sensor_index) < SENSOR_COUNT;

endmodule

`default_nettype wire

// File: hdl/edrf_queue.sv
// ----------------------------------------------------------------------------
// Echo distance rank filter queue
// Short queue of classified readings between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module edrf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  edrf_pkg::edrf_cls_t wr_data,
	input  logic                pop,
	output logic                empty,
	output edrf_pkg::edrf_cls_t rd_data
);
	import edrf_pkg::*;

	edrf_cls_t         slot_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = count_q == (Q_AW + 1)'(Q_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// File: hdl/edrf_back.sv
// ----------------------------------------------------------------------------
// Echo distance rank filter back end
// Keeps the per-sensor windows, selects the ranked reading and holds results.
// ----------------------------------------------------------------------------
`default_nettype none

module edrf_back #(
	parameter int SENSOR_COUNT  = edrf_pkg::SENSOR_COUNT_DEF,
	parameter int WINDOW_LENGTH = edrf_pkg::WINDOW_LENGTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  edrf_pkg::edrf_cls_t q_data,
	output logic                q_pop,
	input  logic [3:0]          rank,
	input  logic                pop,
	output logic                empty,
	output edrf_pkg::edrf_out_t result
);
	import edrf_pkg::*;

	localparam int SENS_AW   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam int WIN_DEPTH = SENSOR_COUNT * WINDOW_LENGTH;
	localparam int WADDR_W   = $clog2(WIN_DEPTH);
	localparam int IDX_W     = $clog2(WINDOW_LENGTH);
	localparam int CNT_W     = $clog2(WINDOW_LENGTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_LOAD,
		ST_SEL,
		ST_DONE
	} state_t;

	state_t                   state_q;
	edrf_cls_t                ent_q;
	logic [WADDR_W-1:0]       base_q;
	logic [CNT_W-1:0]         issue_q;
	logic                     pend_q;
	logic [IDX_W-1:0]         cand_q;
	logic                     sel_valid_q;
	logic [8:0]               sel_cm_q;
	logic [8:0]               win_q [WINDOW_LENGTH];
	logic [SENSOR_COUNT-1:0]  fill_valid_q;
	logic                     out_valid_q;
	edrf_out_t                result_q;

	logic [IDX_W-1:0]         fill_mem [SENSOR_COUNT];
	logic [IDX_W-1:0]         fill_rd_q;
	logic [8:0]               window_mem [WIN_DEPTH];
	logic [8:0]               win_rd_q;

	logic [SENS_AW-1:0]       head_addr;
	logic [SENS_AW-1:0]       ent_addr;
	logic [IDX_W-1:0]         fill_now;
	logic [CNT_W-1:0]         fill_next;
	logic                     win_full;
	logic [WADDR_W-1:0]       wr_base;
	logic [WADDR_W-1:0]       wr_addr;
	logic [WADDR_W-1:0]       rd_addr;
	logic                     fill_wr_en;
	logic [IDX_W-1:0]         fill_wr_data;
	logic                     issue_more;
	logic [CNT_W-1:0]         rank_k;
	logic [8:0]               cand_cm;
	logic [WINDOW_LENGTH-1:0] lt_vec;
	logic [WINDOW_LENGTH-1:0] le_vec;
	logic [CNT_W-1:0]         lt_cnt;
	logic [CNT_W-1:0]         le_cnt;
	logic                     cand_hit;
	logic                     res_load;

	assign head_addr  = SENS_AW'(q_data.sensor);
	assign ent_addr   = SENS_AW'(ent_q.sensor);
	assign q_pop      = (state_q == ST_IDLE) && !q_empty;
	assign fill_now   = fill_valid_q[ent_addr] ? fill_rd_q : '0;
	assign fill_next  = CNT_W'(fill_now) + 1'b1;
	assign win_full   = fill_next == CNT_W'(WINDOW_LENGTH);
	assign wr_base    = WADDR_W'(ent_addr) * WADDR_W'(WINDOW_LENGTH);
	assign wr_addr    = wr_base + WADDR_W'(fill_now);
	assign rd_addr    = base_q + WADDR_W'(issue_q);
	assign fill_wr_en = state_q == ST_FILL;
	assign fill_wr_data = win_full ? '0 : fill_next[IDX_W-1:0];
	assign issue_more = issue_q != CNT_W'(WINDOW_LENGTH);
	assign res_load   = (state_q == ST_DONE) && (!out_valid_q || pop);

	// A rank of zero counts as one and a rank past the window as the largest.
	always_comb begin
		if (rank == '0) begin
			rank_k = CNT_W'(1);
		end else if (32'(rank) > WINDOW_LENGTH) begin
			rank_k = CNT_W'(WINDOW_LENGTH);
		end else begin
			rank_k = CNT_W'(rank);
		end
	end

	// The candidate is the ranked value when fewer than k readings lie below it
	// and at least k readings lie at or below it; ties are thereby counted apart.
	assign cand_cm = win_q[cand_q];

	always_comb begin
		for (int j = 0; j < WINDOW_LENGTH; j++) begin
			lt_vec[j] = win_q[j] < cand_cm;
			le_vec[j] = win_q[j] <= cand_cm;
		end
	end

	assign lt_cnt   = CNT_W'($countones(lt_vec));
	assign le_cnt   = CNT_W'($countones(le_vec));
	assign cand_hit = (lt_cnt < rank_k) && (rank_k <= le_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ent_q        <= '0;
			base_q       <= '0;
			issue_q      <= '0;
			pend_q       <= 1'b0;
			cand_q       <= '0;
			sel_valid_q  <= 1'b0;
			sel_cm_q     <= '0;
			win_q        <= '{default: '0};
			fill_valid_q <= '0;
			out_valid_q  <= 1'b0;
			result_q     <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						ent_q       <= q_data;
						sel_valid_q <= 1'b0;
						sel_cm_q    <= '0;
						state_q     <= q_data.in_range ? ST_FILL : ST_DONE;
					end
				end
				ST_FILL: begin
					fill_valid_q[ent_addr] <= 1'b1;
					if (win_full) begin
						base_q  <= wr_base;
						issue_q <= '0;
						pend_q  <= 1'b0;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_LOAD: begin
					// Reads are issued one per cycle and land in the next cycle.
					if (issue_more) begin
						issue_q <= issue_q + 1'b1;
					end
					pend_q <= issue_more;
					if (pend_q) begin
						for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
							win_q[i] <= win_q[i + 1];
						end
						win_q[WINDOW_LENGTH - 1] <= win_rd_q;
					end
					if (pend_q && !issue_more) begin
						cand_q  <= '0;
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (cand_hit) begin
						sel_cm_q    <= cand_cm;
						sel_valid_q <= 1'b1;
						state_q     <= ST_DONE;
					end else begin
						cand_q <= cand_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						result_q.sensor_out     <= ent_q.sensor;
						result_q.distance_cm    <= ent_q.distance_cm;
						result_q.selected_valid <= sel_valid_q;
						result_q.selected_cm    <= sel_cm_q;
						state_q                 <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fill_wr_en) begin
			fill_mem[ent_addr] <= fill_wr_data;
		end
		if (q_pop) begin
			fill_rd_q <= fill_mem[head_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (fill_wr_en) begin
			window_mem[wr_addr] <= ent_q.distance_cm;
		end
		win_rd_q <= window_mem[rd_addr];
	end

	assign empty  = !out_valid_q;
	assign result = result_q;

endmodule

`default_nettype wire

// File: hdl/echo_distance_rank_filter_top.sv
// ----------------------------------------------------------------------------
// Echo distance rank filter
// Converts echo readings to distances and reports a ranked value per window.
// ----------------------------------------------------------------------------
// Readings are written through push/full like a queue; a request is taken on
// a clock edge with push high and full low. Results are read through
// empty/pop: the oldest result sits on result while empty is low and leaves
// on an edge with pop high. Every reading gives exactly one result.
// The front end registers each reading, converts its echo time and hands it to
// a two-entry queue; the back end takes one reading at a time from it.
// A reading that does not complete its window passes the back end through
// ST_IDLE, ST_FILL and ST_DONE (one out of range skips ST_FILL), while the
// front end and queue keep taking new requests. A reading that completes
// its window also passes ST_LOAD, which reads the window back from the
// window memory, and ST_SEL, which searches it for the ranked value.
// If pop stays low the result is held, the back end waits and the queue and
// front end keep taking requests until full rises. Reset empties the block,
// clears all fill counts and sets rank to 4 and the timeout to 23000 us.
// Configuration writes are always ready and should be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module echo_distance_rank_filter_top #(
	parameter int SENSOR_COUNT  = edrf_pkg::SENSOR_COUNT_DEF,
	parameter int WINDOW_LENGTH = edrf_pkg::WINDOW_LENGTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  edrf_pkg::edrf_in_t                 item,
	output logic                               empty,
	input  logic                               pop,
	output edrf_pkg::edrf_out_t                result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [edrf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [15:0]                        cfg_data
);
	import edrf_pkg::*;

	logic [3:0]  rank_q;
	logic [15:0] timeout_q;
	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	edrf_cls_t   q_wr_data;
	edrf_cls_t   q_rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q    <= RANK_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RANK:    rank_q    <= cfg_data[3:0];
				CFG_TIMEOUT: timeout_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	edrf_front #(
		.SENSOR_COUNT(SENSOR_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.timeout_us(timeout_q),
		.q_push    (q_push),
		.q_data    (q_wr_data),
		.q_full    (q_full)
	);

	edrf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.wr_data(q_wr_data),
		.pop    (q_pop),
		.empty  (q_empty),
		.rd_data(q_rd_data)
	);

	edrf_back #(
		.SENSOR_COUNT (SENSOR_COUNT),
		.WINDOW_LENGTH(WINDOW_LENGTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_data (q_rd_data),
		.q_pop  (q_pop),
		.rank   (rank_q),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

`default_nettype wire

// File: hdl/edrf_checker.sv
// ----------------------------------------------------------------------------
// Echo distance rank filter checker
// Port-level properties of the filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module edrf_checker #(
	parameter int SENSOR_COUNT = edrf_pkg::SENSOR_COUNT_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input edrf_pkg::edrf_out_t result
);
	import edrf_pkg::*;

	// A result that is not taken stays on the ports unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while stalled");

	a_sel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.selected_valid |-> result.selected_cm == '0)
		else $error("selected distance set without a completed window");

	a_sel_sensor: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.selected_valid |-> 32'(result.sensor_out) < SENSOR_COUNT)
		else $error("window completed for a sensor that does not exist");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.distance_cm <= NO_ECHO_CM) && (result.selected_cm <= NO_ECHO_CM))
		else $error("distance beyond the no-echo value");

endmodule

bind echo_distance_rank_filter_top edrf_checker #(
	.SENSOR_COUNT(SENSOR_COUNT)
) u_edrf_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.empty (empty),
	.pop   (pop),
	.result(result)
);

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Echo distance rank filter testbench
// Sends echo readings through the push/full side under random idling on
// both sides, predicts each result from a model of the per-sensor windows,
// and checks every popped result field by field, in order. Rank and timeout
// are changed between phases while the filter is idle, extremes included.
// ----------------------------------------------------------------------------

module tb;

	import edrf_pkg::*;

	localparam int SENSORS        = SENSOR_COUNT_DEF;
	localparam int WINDOW         = WINDOW_LENGTH_DEF;
	localparam int ECHO_US_PER_CM = 58;
	localparam int REPORT_LIMIT   = 10;
	localparam int TAIL_CYCLES    = 40;

	// Predicts the result of each accepted request and checks the popped ones.
	class echo_rank_board;
		logic [8:0]  readings [SENSORS][WINDOW];
		int unsigned held [SENSORS];
		logic [3:0]  rank_reg;
		logic [15:0] timeout_reg;
		edrf_out_t   pending_results [$];
		int unsigned mismatches;
		int unsigned readings_noted;
		int unsigned results_checked;
		int unsigned windows_closed;

		function new();
			rank_reg        = RANK_RESET;
			timeout_reg     = TIMEOUT_RESET;
			mismatches      = 0;
			readings_noted  = 0;
			results_checked = 0;
			windows_closed  = 0;
			foreach (held[i])
				held[i] = 0;
		endfunction

		function logic [8:0] echo_cm(logic seen, logic [15:0] t);
			int unsigned q;
			if (!seen || t >= timeout_reg)
				return NO_ECHO_CM;
			q = t / ECHO_US_PER_CM;
			if (q > NO_ECHO_CM)
				return NO_ECHO_CM;
			return q[8:0];
		endfunction

		// The k-th smallest is the value with fewer than k entries strictly
		// below it and at least k entries at or below it, so ties count apart.
		function logic [8:0] nth_smallest(int unsigned s, int unsigned k);
			int unsigned below;
			int unsigned upto;
			for (int i = 0; i < WINDOW; i++) begin
				below = 0;
				upto  = 0;
				for (int j = 0; j < WINDOW; j++) begin
					if (readings[s][j] < readings[s][i])
						below++;
					if (readings[s][j] <= readings[s][i])
						upto++;
				end
				if (below < k && k <= upto)
					return readings[s][i];
			end
			return '0;
		endfunction

		function void note_reading(edrf_in_t rd);
			edrf_out_t   want;
			int unsigned s;
			int unsigned k;
			s                   = 32'(rd.sensor_index);
			want.sensor_out     = rd.sensor_index;
			want.distance_cm    = echo_cm(rd.echo_seen, rd.echo_time_us);
			want.selected_valid = 1'b0;
			want.selected_cm    = '0;
			if (s < SENSORS) begin
				if (held[s] >= WINDOW)
					held[s] = 0;
				readings[s][held[s]] = want.distance_cm;
				held[s]++;
				if (held[s] == WINDOW) begin
					k = 32'(rank_reg);
					if (k < 1)
						k = 1;
					if (k > WINDOW)
						k = WINDOW;
					want.selected_valid = 1'b1;
					want.selected_cm    = nth_smallest(s, k);
					held[s]             = 0;
					windows_closed++;
				end
			end
			pending_results.push_back(want);
			readings_noted++;
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%s", what);
		endfunction

		function void check_result(edrf_out_t got);
			edrf_out_t want;
			results_checked++;
			if (pending_results.size() == 0) begin
				flag($sformatf("unexpected result: sensor %0d distance %0d valid %0b selected %0d",
					got.sensor_out, got.distance_cm, got.selected_valid, got.selected_cm));
				return;
			end
			want = pending_results.pop_front();
			if (got.sensor_out !== want.sensor_out || got.distance_cm !== want.distance_cm ||
			    got.selected_valid !== want.selected_valid ||
			    got.selected_cm !== want.selected_cm)
				flag($sformatf({"result %0d mismatch: sensor %0d/%0d distance %0d/%0d ",
					"valid %0b/%0b selected %0d/%0d (expected/actual)"},
					results_checked, want.sensor_out, got.sensor_out,
					want.distance_cm, got.distance_cm, want.selected_valid,
					got.selected_valid, want.selected_cm, got.selected_cm));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   push;
	logic                   full;
	edrf_in_t               item;
	logic                   empty;
	logic                   pop = 1'b0;
	edrf_out_t              result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [15:0]            cfg_data;

	echo_rank_board ranks;
	int unsigned    push_idle_pct = 0;
	int unsigned    pop_idle_pct  = 0;
	int unsigned    pop_stall     = 0;
	int unsigned    settings_used = 0;

	echo_distance_rank_filter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// No gap unless pct hits; then mostly a short gap and now and then a long one.
	function automatic int unsigned idle_gap(int unsigned pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			ranks.check_result(result);
		if (pop_stall != 0) begin
			pop <= 1'b0;
			pop_stall--;
		end else begin
			pop <= 1'b1;
			pop_stall = idle_gap(pop_idle_pct);
		end
	end

	function automatic edrf_in_t make_reading(logic [3:0] s, logic seen, logic [15:0] t);
		edrf_in_t rd;
		rd.sensor_index = s;
		rd.echo_seen    = seen;
		rd.echo_time_us = t;
		return rd;
	endfunction

	// Push stays high between back-to-back requests; this task lowers it only for a gap.
	task automatic send_reading(edrf_in_t rd);
		int unsigned gap;
		gap = idle_gap(push_idle_pct);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= rd;
		do @(posedge clk); while (full);
		ranks.note_reading(rd);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_RANK)
			ranks.rank_reg = data[3:0];
		else if (idx == CFG_TIMEOUT)
			ranks.timeout_reg = data;
	endtask

	// Only the low four bits of a rank write matter, so the rest is filled at random.
	task automatic configure(logic [3:0] rank_val, logic [15:0] timeout_val);
		logic [11:0] filler;
		filler = 12'($urandom);
		write_reg(CFG_RANK, {filler, rank_val});
		write_reg(CFG_TIMEOUT, timeout_val);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (ranks.pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] random_echo(logic [15:0] prev, logic [15:0] tmo);
		int unsigned pick;
		int          t;
		logic [15:0] r;
		pick = $urandom_range(0, 99);
		r    = 16'($urandom);
		if (pick < 50)
			return 16'($urandom_range(0, 23999));
		if (pick < 70)
			return r;
		if (pick < 85)
			return prev;
		t = int'(tmo) + int'($urandom_range(0, 4)) - 2;
		if (t < 0)
			t = 0;
		if (t > 65535)
			t = 65535;
		return t[15:0];
	endfunction

	// Readings go mostly to the first span sensors so that windows close often.
	task automatic random_phase(int unsigned count, int unsigned span,
	                            int unsigned push_pct, int unsigned pop_pct);
		edrf_in_t    rd;
		logic [15:0] prev;
		push_idle_pct = push_pct;
		pop_idle_pct  = pop_pct;
		prev          = '0;
		repeat (count) begin
			if ($urandom_range(0, 99) < 8)
				rd.sensor_index = 4'($urandom_range(SENSORS, 15));
			else
				rd.sensor_index = 4'($urandom_range(0, span - 1));
			rd.echo_seen    = ($urandom_range(0, 9) != 0);
			rd.echo_time_us = random_echo(prev, ranks.timeout_reg);
			prev            = rd.echo_time_us;
			send_reading(rd);
		end
		drain();
	endtask

	initial begin
		ranks     = new();
		arst_n    = 1'b0;
		push      = 1'b0;
		item      = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_RANK;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// One window under the reset settings: edges of the conversion and ties.
		push_idle_pct = 25;
		pop_idle_pct  = 25;
		send_reading(make_reading(4'd0, 1'b1, 16'd0));
		send_reading(make_reading(4'd0, 1'b1, 16'd57));
		send_reading(make_reading(4'd0, 1'b1, 16'd58));
		send_reading(make_reading(4'd0, 1'b1, 16'd22999));
		send_reading(make_reading(4'd0, 1'b1, 16'd23000));
		send_reading(make_reading(4'd0, 1'b0, 16'd100));
		send_reading(make_reading(4'd0, 1'b1, 16'd65535));
		send_reading(make_reading(4'd0, 1'b1, 16'd58));
		send_reading(make_reading(4'd0, 1'b1, 16'd5800));
		send_reading(make_reading(4'd0, 1'b0, 16'd0));
		// Sensors outside the array leave every window alone.
		send_reading(make_reading(4'd15, 1'b1, 16'd1160));
		send_reading(make_reading(4'd10, 1'b0, 16'd65535));
		drain();

		// Rank zero with the longest timeout: long echoes saturate at 400 cm.
		configure(4'd0, 16'hFFFF);
		send_reading(make_reading(4'd9, 1'b1, 16'd65534));
		send_reading(make_reading(4'd9, 1'b1, 16'd23200));
		send_reading(make_reading(4'd9, 1'b1, 16'd23258));
		send_reading(make_reading(4'd9, 1'b1, 16'd23199));
		send_reading(make_reading(4'd9, 1'b1, 16'd0));
		send_reading(make_reading(4'd9, 1'b1, 16'd32767));
		send_reading(make_reading(4'd9, 1'b1, 16'd116));
		send_reading(make_reading(4'd9, 1'b1, 16'd116));
		send_reading(make_reading(4'd9, 1'b0, 16'd116));
		send_reading(make_reading(4'd9, 1'b1, 16'd65535));
		drain();

		// A zero timeout turns every echo into no echo.
		configure(4'd15, 16'd0);
		send_reading(make_reading(4'd3, 1'b1, 16'd0));
		send_reading(make_reading(4'd3, 1'b1, 16'd1));
		send_reading(make_reading(4'd3, 1'b1, 16'd58));
		drain();

		configure(4'd1, 16'hFFFF);
		random_phase(205, 10, 0, 0);
		configure(4'd10, 16'd1);
		random_phase(205, 3, 30, 30);
		configure(4'd0, 16'd0);
		random_phase(205, 2, 20, 60);
		configure(4'd15, 16'd23000);
		random_phase(205, 10, 60, 10);
		configure(4'd7, 16'd40000);
		random_phase(205, 5, 10, 10);
		configure(4'($urandom_range(1, 10)), 16'($urandom_range(1, 65535)));
		random_phase(205, 10, 30, 30);
		configure(4'd2, 16'd23200);
		random_phase(205, 1, 0, 50);
		configure(4'd12, 16'($urandom_range(300, 30000)));
		random_phase(205, 10, 50, 0);

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d readings and %0d checked results, %0d of them closing a window,",
			ranks.readings_noted, ranks.results_checked, ranks.windows_closed);
		$display("across %0d rank and timeout settings; %0d mismatches, %0d results outstanding.",
			settings_used + 1, ranks.mismatches, ranks.pending_results.size());
		if (ranks.mismatches == 0 && ranks.pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d results outstanding.", ranks.pending_results.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
